@@ design/bmp_pkg.sv @@
// shared types, constants and widths for the binomial mod prime block
package bmp_pkg;

   localparam int unsigned TABLE_SIZE = 4096;
   localparam int unsigned ADDR_W     = $clog2(TABLE_SIZE);
   localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int unsigned VAL_W      = 30;
   localparam int unsigned ARG_W      = 12;
   localparam int unsigned MUL_LAT    = 4;

   localparam logic [VAL_W-1:0] PRIME     = 30'd1000000007;
   localparam logic [VAL_W-1:0] PRIME_EXP = 30'd1000000005;
   localparam logic [63:0]      MU_FULL   = (64'd1 << 60) / 64'(PRIME);
   localparam logic [30:0]      MU        = MU_FULL[30:0];

   typedef struct packed {
      logic [ARG_W-1:0] n;
      logic [ARG_W-1:0] r;
   } bmp_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             bad_args;
   } bmp_rsp_type;

   typedef enum logic [2:0] {
      ST_SEED,
      ST_FACT,
      ST_POW_MUL,
      ST_POW_SQ,
      ST_INV,
      ST_DONE
   } bmp_state_type;

   typedef struct packed {
      logic              fact_we;
      logic              inv_we;
      logic [ADDR_W-1:0] addr;
      logic [VAL_W-1:0]  data;
      logic              issue;
      logic [VAL_W-1:0]  a;
      logic [VAL_W-1:0]  b;
   } bmp_bld_type;

endpackage

@@ design/bmp_ram.sv @@
// generic single write port ram with registered read
module bmp_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ design/bmp_mulmod.sv @@
// four stage modular multiplier, barrett reduction
module bmp_mulmod (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [bmp_pkg::VAL_W-1:0] a,
   input  logic [bmp_pkg::VAL_W-1:0] b,
   output logic                  out_valid,
   output logic [bmp_pkg::VAL_W-1:0] p
);
   import bmp_pkg::*;

   logic [MUL_LAT-1:0] v_ff;
   logic [59:0]        x_ff;
   logic [31:0]        xlo_ff;
   logic [30:0]        q3_ff;
   logic [31:0]        rem_ff;
   logic [VAL_W-1:0]   p_ff;

   logic [61:0]        q2;
   logic [60:0]        qp;
   logic [31:0]        rem_in;
   logic [31:0]        p1;
   logic [31:0]        p2;
   logic [VAL_W-1:0]   p_in;

   assign q2     = 62'(x_ff[59:29]) * 62'(MU);
   assign qp     = 61'(q3_ff) * 61'(PRIME);
   assign rem_in = xlo_ff - qp[31:0];
   assign p1     = 32'(PRIME);
   assign p2     = 32'(PRIME) << 1;

   always_comb begin
      if (rem_ff >= p2) begin
         p_in = VAL_W'(rem_ff - p2);
      end else if (rem_ff >= p1) begin
         p_in = VAL_W'(rem_ff - p1);
      end else begin
         p_in = VAL_W'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[MUL_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= 60'(a) * 60'(b);
         q3_ff  <= q2[61:31];
         xlo_ff <= x_ff[31:0];
         rem_ff <= rem_in;
         p_ff   <= p_in;
      end
   end

   assign out_valid = v_ff[MUL_LAT-1];
   assign p         = p_ff;

endmodule

@@ design/bmp_builder.sv @@
// table build sequencer: factorials, fermat inverse, inverse factorials
module bmp_builder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mul_valid,
   input  logic [bmp_pkg::VAL_W-1:0] mul_p,
   output bmp_pkg::bmp_bld_type      bld,
   output logic                      done
);
   import bmp_pkg::*;

   bmp_state_type    state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] sq_ff, sq_in;
   logic [VAL_W-1:0] exp_ff, exp_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] k_dec;

   assign k_dec = k_ff - 1'b1;

   // next state and datapath registers
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      exp_in   = exp_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         ST_SEED: begin
            state_in = ST_FACT;
            acc_in   = VAL_W'(1);
            k_in     = CNT_W'(1);
         end
         ST_FACT: begin
            if (k_ff == CNT_W'(TABLE_SIZE)) begin
               state_in = ST_POW_MUL;
               sq_in    = acc_ff;
               acc_in   = VAL_W'(1);
               exp_in   = PRIME_EXP;
            end else if (mul_valid) begin
               acc_in  = mul_p;
               k_in    = k_ff + 1'b1;
               pend_in = 1'b0;
            end else begin
               pend_in = 1'b1;
            end
         end
         ST_POW_MUL: begin
            if (exp_ff == '0) begin
               state_in = ST_INV;
               k_in     = k_dec;
            end else if (!exp_ff[0]) begin
               state_in = ST_POW_SQ;
            end else if (mul_valid) begin
               acc_in   = mul_p;
               pend_in  = 1'b0;
               state_in = ST_POW_SQ;
            end else begin
               pend_in = 1'b1;
            end
         end
         ST_POW_SQ: begin
            if (mul_valid) begin
               sq_in    = mul_p;
               exp_in   = exp_ff >> 1;
               pend_in  = 1'b0;
               state_in = ST_POW_MUL;
            end else begin
               pend_in = 1'b1;
            end
         end
         ST_INV: begin
            if (k_ff == '0) begin
               state_in = ST_DONE;
            end else if (mul_valid) begin
               acc_in  = mul_p;
               k_in    = k_dec;
               pend_in = 1'b0;
            end else begin
               pend_in = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_DONE;
         end
         default: begin
            state_in = ST_SEED;
         end
      endcase
   end

   // outputs: multiplier issue and table writes
   always_comb begin
      bld      = '0;
      bld.a    = acc_ff;
      bld.b    = VAL_W'(k_ff);
      bld.addr = k_ff[ADDR_W-1:0];
      bld.data = mul_p;
      unique case (state_ff)
         ST_SEED: begin
            bld.fact_we = 1'b1;
            bld.addr    = '0;
            bld.data    = VAL_W'(1);
         end
         ST_FACT: begin
            bld.issue   = (k_ff != CNT_W'(TABLE_SIZE)) && !pend_ff;
            bld.fact_we = mul_valid;
         end
         ST_POW_MUL: begin
            bld.b      = sq_ff;
            bld.issue  = (exp_ff != '0) && exp_ff[0] && !pend_ff;
            // last step writes the inverse of the top factorial
            bld.inv_we = (exp_ff == '0);
            bld.addr   = k_dec[ADDR_W-1:0];
            bld.data   = acc_ff;
         end
         ST_POW_SQ: begin
            bld.a     = sq_ff;
            bld.b     = sq_ff;
            bld.issue = !pend_ff;
         end
         ST_INV: begin
            bld.issue  = (k_ff != '0) && !pend_ff;
            bld.inv_we = mul_valid;
            bld.addr   = k_dec[ADDR_W-1:0];
         end
         ST_DONE: begin
            bld.issue = 1'b0;
         end
         default: begin
            bld.issue = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEED;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      exp_ff <= exp_in;
   end

   assign done = (state_ff == ST_DONE);

endmodule

@@ design/binomial_mod_prime_core.sv @@
// binomial coefficient mod 1000000007, pipelined over factorial tables
// path: table read register, multiplier A, multiplier B, then the output register
// throughput: one item per cycle; a stalled output holds the whole pipeline
// reset: after reset the builder fills the factorial and inverse factorial tables,
//   with req_stall high until done
// the whole build shares the first modular multiplier with the query path
module binomial_mod_prime_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bmp_pkg::bmp_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bmp_pkg::bmp_rsp_type rsp_payload
);
   import bmp_pkg::*;

   // pipeline control: everything advances unless the output is held
   logic        en;
   logic        done;
   logic        accept;
   bmp_bld_type bld;

   // stage 0: argument check and table addresses
   logic [31:0]       n_ext;
   logic [31:0]       r_ext;
   logic [31:0]       nr_ext;
   logic              bad_in;
   logic [ARG_W-1:0]  nr;

   // stage 1: table reads land
   logic              s1_valid_ff;
   logic              s1_bad_ff;
   logic [VAL_W-1:0]  fact_n;
   logic [VAL_W-1:0]  inv_r;
   logic [VAL_W-1:0]  inv_nr;

   // multiplier A: inverse of r!(n-r)!, shared with the builder
   logic              mua_valid;
   logic [VAL_W-1:0]  mua_p;
   logic              mua_in_valid;
   logic [VAL_W-1:0]  mua_a;
   logic [VAL_W-1:0]  mua_b;

   // multiplier B: n! times that inverse
   logic              mub_valid;
   logic [VAL_W-1:0]  mub_p;

   // side delay lines
   logic [VAL_W-1:0]  fact_dly_ff [MUL_LAT];
   logic [2*MUL_LAT-1:0] bad_dly_ff;

   // output register
   logic              rsp_valid_ff;
   bmp_rsp_type       rsp_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !done || !en;
   assign accept    = req_valid && !req_stall;

   // r > n and n beyond the table both give an error item
   assign nr     = req_payload.n - req_payload.r;
   assign n_ext  = 32'(req_payload.n);
   assign r_ext  = 32'(req_payload.r);
   assign nr_ext = 32'(nr);
   assign bad_in = (req_payload.r > req_payload.n) || (n_ext >= 32'(TABLE_SIZE));

   bmp_builder u_builder (
      .clock     (clock),
      .reset     (reset),
      .mul_valid (mua_valid),
      .mul_p     (mua_p),
      .bld       (bld),
      .done      (done)
   );

   bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_fact_ram (
      .clock (clock),
      .we    (bld.fact_we),
      .waddr (bld.addr),
      .wdata (bld.data),
      .re    (en),
      .raddr (n_ext[ADDR_W-1:0]),
      .rdata (fact_n)
   );

   // two copies of the inverse table give two read ports
   bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_inv_r_ram (
      .clock (clock),
      .we    (bld.inv_we),
      .waddr (bld.addr),
      .wdata (bld.data),
      .re    (en),
      .raddr (r_ext[ADDR_W-1:0]),
      .rdata (inv_r)
   );

   bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_inv_nr_ram (
      .clock (clock),
      .we    (bld.inv_we),
      .waddr (bld.addr),
      .wdata (bld.data),
      .re    (en),
      .raddr (nr_ext[ADDR_W-1:0]),
      .rdata (inv_nr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_bad_ff <= bad_in;
      end
   end

   // builder owns multiplier A until the tables are complete
   assign mua_in_valid = done ? s1_valid_ff : bld.issue;
   assign mua_a        = done ? inv_r : bld.a;
   assign mua_b        = done ? inv_nr : bld.b;

   bmp_mulmod u_mul_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mua_in_valid),
      .a         (mua_a),
      .b         (mua_b),
      .out_valid (mua_valid),
      .p         (mua_p)
   );

   bmp_mulmod u_mul_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mua_valid && done),
      .a         (fact_dly_ff[MUL_LAT-1]),
      .b         (mua_p),
      .out_valid (mub_valid),
      .p         (mub_p)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         fact_dly_ff[0] <= fact_n;
         for (int i = 1; i < MUL_LAT; i++) begin
            fact_dly_ff[i] <= fact_dly_ff[i-1];
         end
         bad_dly_ff <= {bad_dly_ff[2*MUL_LAT-2:0], s1_bad_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= mub_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.bad_args <= bad_dly_ff[2*MUL_LAT-1];
         rsp_ff.value    <= bad_dly_ff[2*MUL_LAT-1] ? '0 : mub_p;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/bmp_checker.sv @@
// port level checks for the binomial mod prime core, with bind
module bmp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input bmp_pkg::bmp_req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input bmp_pkg::bmp_rsp_type rsp_payload
);
   import bmp_pkg::*;

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   // error items carry zero
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_args |-> rsp_payload.value == '0)
      else $error("error item with nonzero value");

   // results are reduced
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.value < PRIME)
      else $error("value not reduced mod prime");

   // table build blocks input right after reset
   a_build_stall: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input taken during table build");

endmodule

bind binomial_mod_prime_core bmp_checker u_bmp_checker (.*);
